// ===== src/pia_pkg.sv =====
// Shared types and constants for the parallel interface adapter.
package pia_pkg;

  // Command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Register offsets for bus read/write
  localparam logic [1:0] REG_PRA = 2'd0;
  localparam logic [1:0] REG_CRA = 2'd1;
  localparam logic [1:0] REG_PRB = 2'd2;
  localparam logic [1:0] REG_CRB = 2'd3;

  // Targets for set/clear
  localparam logic [1:0] IN_PINS_A = 2'd0;
  localparam logic [1:0] IN_PINS_B = 2'd1;
  localparam logic [1:0] IN_CA     = 2'd2;
  localparam logic [1:0] IN_CB     = 2'd3;

  // Control register fields
  localparam logic [7:0] CTRL_WR_MASK   = 8'h3f;
  localparam logic [7:0] CTRL_FLAG_MASK = 8'hc0;
  localparam logic [2:0] C2_HANDSHAKE   = 3'b100;

  typedef struct packed {
    logic rd_port;     // read of data/direction offset
    logic wr_port;     // write of data/direction offset
    logic wr_ctrl;     // write of control register
    logic pin_op;      // set/clear of input pins
    logic line_op;     // set/clear of C1/C2 lines
    logic setting;     // 1 set, 0 clear
    logic drop_c2_rd;  // handshake drop on data read (side A)
    logic drop_c2_wr;  // handshake drop on data write (side B)
  } side_req_t;

  typedef struct packed {
    logic [7:0] port_rd;   // data or direction read value
    logic [7:0] ctrl;      // current control register
    logic [1:0] irq_cnt;
    logic       c2;        // C2 level after the step
    logic       chg;
    logic       chg_ctrl;  // change was on the control register
    logic [7:0] chg_old;
    logic [7:0] chg_new;
  } side_stat_t;

endpackage

// ===== src/pia_if.sv =====
// Valid/ready channel interfaces for command and result beats.
interface pia_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [1:0] target;
  logic [7:0] data;

  modport source (output valid, command, target, data, input ready);
  modport sink   (input valid, command, target, data, output ready);
endinterface

interface pia_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] irq_a_count;
  logic [1:0] irq_b_count;
  logic       ca2_level;
  logic       cb2_level;
  logic       change_valid;
  logic [1:0] change_which;
  logic [7:0] change_old;
  logic [7:0] change_new;

  modport source (output valid, read_data, irq_a_count, irq_b_count, ca2_level,
                  cb2_level, change_valid, change_which, change_old, change_new,
                  input ready);
  modport sink   (input valid, read_data, irq_a_count, irq_b_count, ca2_level,
                  cb2_level, change_valid, change_which, change_old, change_new,
                  output ready);
endinterface

// ===== src/peripheral_interface_adapter_core.sv =====
// Top level of the two-port parallel interface adapter.
//
// Usage:
//   cmd  (sink)  : one beat per command {command, target, data}. Commands are
//                  bus read, bus write, and set and clear of input pins or C1/C2 lines.
//   res  (source): exactly one result beat per command, in order, carrying
//                  read data, interrupt pulse counts per side, the CA2/CB2
//                  levels after the command, and register change info.
// Timing:
//   A command beat lands in an input register, is applied to the port state
//   by one pass of masking logic and lands in the result register. One
//   command per cycle is sustained while res takes beats; the limit is the
//   single state update per cycle on the side registers.
// Stall:
//   When res is held off, the result register keeps its beat, the input
//   register still holds one more command, and cmd.ready drops only once
//   both are full. Nothing is lost or repeated.
// Reset:
//   rst (synchronous) clears all port registers, pins, lines, C2 outputs
//   and both pipeline valid bits.
module peripheral_interface_adapter_core (
  input logic      clk,
  input logic      rst,
  pia_cmd_if.sink  cmd,
  pia_res_if.source res
);

  // Input register
  logic       stage_valid;
  logic [1:0] stage_cmd;
  logic [1:0] stage_tgt;
  logic [7:0] stage_data;

  // Result register
  logic       res_valid;
  logic [7:0] res_read_data;
  logic [1:0] res_irq_a, res_irq_b;
  logic       res_ca2, res_cb2;
  logic       res_chg;
  logic [1:0] res_which;
  logic [7:0] res_old, res_new;

  logic advance;   // result register can take a beat this cycle
  logic step;      // staged command is applied this cycle

  assign advance   = ~res_valid | res.ready;
  assign step      = stage_valid & advance;
  assign cmd.ready = ~stage_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      stage_cmd  <= cmd.command;
      stage_tgt  <= cmd.target;
      stage_data <= cmd.data;
    end
  end

  // Command decode, gated by step so idle cycles leave the state alone
  logic is_rd, is_wr, is_pin;
  pia_pkg::side_req_t req_a, req_b;
  pia_pkg::side_stat_t stat_a, stat_b;

  always_comb begin
    is_rd  = step & (stage_cmd == pia_pkg::CMD_READ);
    is_wr  = step & (stage_cmd == pia_pkg::CMD_WRITE);
    is_pin = step & ((stage_cmd == pia_pkg::CMD_SET) | (stage_cmd == pia_pkg::CMD_CLEAR));

    req_a.rd_port    = is_rd & (stage_tgt == pia_pkg::REG_PRA);
    req_a.wr_port    = is_wr & (stage_tgt == pia_pkg::REG_PRA);
    req_a.wr_ctrl    = is_wr & (stage_tgt == pia_pkg::REG_CRA);
    req_a.pin_op     = is_pin & (stage_tgt == pia_pkg::IN_PINS_A);
    req_a.line_op    = is_pin & (stage_tgt == pia_pkg::IN_CA);
    req_a.setting    = (stage_cmd == pia_pkg::CMD_SET);
    req_a.drop_c2_rd = 1'b1;   // CA2 handshake ends on port A read
    req_a.drop_c2_wr = 1'b0;

    req_b.rd_port    = is_rd & (stage_tgt == pia_pkg::REG_PRB);
    req_b.wr_port    = is_wr & (stage_tgt == pia_pkg::REG_PRB);
    req_b.wr_ctrl    = is_wr & (stage_tgt == pia_pkg::REG_CRB);
    req_b.pin_op     = is_pin & (stage_tgt == pia_pkg::IN_PINS_B);
    req_b.line_op    = is_pin & (stage_tgt == pia_pkg::IN_CB);
    req_b.setting    = (stage_cmd == pia_pkg::CMD_SET);
    req_b.drop_c2_rd = 1'b0;
    req_b.drop_c2_wr = 1'b1;   // CB2 handshake ends on port B write
  end

  pia_side u_side_a (
    .clk  (clk),
    .rst  (rst),
    .data (stage_data),
    .req  (req_a),
    .stat (stat_a)
  );

  pia_side u_side_b (
    .clk  (clk),
    .rst  (rst),
    .data (stage_data),
    .req  (req_b),
    .stat (stat_b)
  );

  // Result assembly; reads see state from before this command
  logic [7:0] rd_val;
  logic       chg_any;
  logic [1:0] which_val;
  logic [7:0] old_val, new_val;

  always_comb begin
    rd_val = 8'h00;
    if (stage_cmd == pia_pkg::CMD_READ) begin
      case (stage_tgt)
        pia_pkg::REG_PRA: rd_val = stat_a.port_rd;
        pia_pkg::REG_CRA: rd_val = stat_a.ctrl;
        pia_pkg::REG_PRB: rd_val = stat_b.port_rd;
        pia_pkg::REG_CRB: rd_val = stat_b.ctrl;
        default:          rd_val = 8'h00;
      endcase
    end
    // at most one side reports a change per command
    chg_any   = stat_a.chg | stat_b.chg;
    which_val = stat_b.chg ? {1'b1, stat_b.chg_ctrl} : {1'b0, stat_a.chg_ctrl};
    old_val   = stat_a.chg_old | stat_b.chg_old;
    new_val   = stat_a.chg_new | stat_b.chg_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_read_data <= rd_val;
      res_irq_a     <= stat_a.irq_cnt;
      res_irq_b     <= stat_b.irq_cnt;
      res_ca2       <= stat_a.c2;
      res_cb2       <= stat_b.c2;
      res_chg       <= chg_any;
      res_which     <= which_val;
      res_old       <= old_val;
      res_new       <= new_val;
    end
  end

  assign res.valid        = res_valid;
  assign res.read_data    = res_read_data;
  assign res.irq_a_count  = res_irq_a;
  assign res.irq_b_count  = res_irq_b;
  assign res.ca2_level    = res_ca2;
  assign res.cb2_level    = res_cb2;
  assign res.change_valid = res_chg;
  assign res.change_which = res_which;
  assign res.change_old   = res_old;
  assign res.change_new   = res_new;

`ifndef ASSERT_OFF
  // Change fields are zero unless a change is flagged
  a_chg_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.change_valid |->
      res.change_old == 8'h00 && res.change_new == 8'h00 && res.change_which == 2'd0)
    else $error("change fields nonzero without change_valid");

  // A write beat never carries read data or interrupt pulses
  a_chg_excl: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.change_valid |->
      res.read_data == 8'h00 && res.irq_a_count == 2'd0 && res.irq_b_count == 2'd0)
    else $error("change beat carries read data or irq pulses");

  // Only one side can raise interrupts per command
  a_irq_one_side: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.irq_a_count == 2'd0 || res.irq_b_count == 2'd0)
    else $error("irq pulses on both sides in one beat");

  // Input register cannot be full with ready high unless it drains now
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |-> !cmd.ready)
    else $error("command accepted over a stalled staged beat");
`endif

endmodule

// ===== src/pia_side.sv =====
// One port side: data, direction and control registers, pins and C1/C2 lines.
module pia_side (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             data,
  input  pia_pkg::side_req_t     req,
  output pia_pkg::side_stat_t    stat
);

  logic [7:0] out_reg, dir_reg, ctrl, pins;
  logic [1:0] lines;
  logic       c2;

  logic [7:0] out_reg_next, dir_reg_next, ctrl_next, pins_next;
  logic [1:0] lines_next;
  logic       c2_next;

  logic [1:0] nl, rise, fall;
  logic       edge1, edge2;
  logic [1:0] pulses;
  logic [7:0] ctrl_wv;

  always_comb begin
    out_reg_next = out_reg;
    dir_reg_next = dir_reg;
    ctrl_next    = ctrl;
    pins_next    = pins;
    lines_next   = lines;
    c2_next      = c2;
    pulses       = 2'd0;
    stat.chg      = 1'b0;
    stat.chg_ctrl = 1'b0;
    stat.chg_old  = 8'h00;
    stat.chg_new  = 8'h00;

    nl    = req.setting ? (lines | data[7:6]) : (lines & ~data[7:6]);
    rise  = nl & ~lines;
    fall  = lines & ~nl;
    edge1 = ctrl[1] ? rise[1] : fall[1];
    edge2 = ~ctrl[5] & (ctrl[4] ? rise[0] : fall[0]);
    ctrl_wv = (ctrl & pia_pkg::CTRL_FLAG_MASK) | (data & pia_pkg::CTRL_WR_MASK);

    if (req.rd_port && ctrl[2]) begin
      ctrl_next = ctrl & pia_pkg::CTRL_WR_MASK;
      if (req.drop_c2_rd && ctrl[5:3] == pia_pkg::C2_HANDSHAKE) c2_next = 1'b0;
    end

    if (req.wr_port) begin
      if (ctrl[2]) begin
        out_reg_next = data;
        stat.chg     = (out_reg != data);
        stat.chg_old = out_reg;
        stat.chg_new = data;
        if (req.drop_c2_wr && ctrl[5:3] == pia_pkg::C2_HANDSHAKE) c2_next = 1'b0;
      end else begin
        dir_reg_next = data;
      end
    end

    if (req.wr_ctrl) begin
      ctrl_next     = ctrl_wv;
      stat.chg      = (ctrl != ctrl_wv);
      stat.chg_ctrl = 1'b1;
      stat.chg_old  = ctrl;
      stat.chg_new  = ctrl_wv;
      // direct mode: C2 follows b3
      if (data[5:4] == 2'b11) c2_next = data[3];
    end

    if (req.pin_op) begin
      pins_next = req.setting ? (pins | data) : (pins & ~data);
    end

    if (req.line_op) begin
      lines_next = nl;
      if (edge1) begin
        ctrl_next[7] = 1'b1;
        if (ctrl[5:3] == pia_pkg::C2_HANDSHAKE) c2_next = 1'b1;
      end
      if (edge2) ctrl_next[6] = 1'b1;
      pulses = 2'({1'b0, edge1 & ctrl[0]}) + 2'({1'b0, edge2 & ctrl[3]});
    end

    if (!stat.chg) begin
      stat.chg_ctrl = 1'b0;
      stat.chg_old  = 8'h00;
      stat.chg_new  = 8'h00;
    end

    stat.port_rd = ctrl[2] ? ((pins & ~dir_reg) | (out_reg & dir_reg)) : dir_reg;
    stat.ctrl    = ctrl;
    stat.irq_cnt = pulses;
    stat.c2      = c2_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg <= 8'h00;
      dir_reg <= 8'h00;
      ctrl    <= 8'h00;
      pins    <= 8'h00;
      lines   <= 2'b00;
      c2      <= 1'b0;
    end else begin
      out_reg <= out_reg_next;
      dir_reg <= dir_reg_next;
      ctrl    <= ctrl_next;
      pins    <= pins_next;
      lines   <= lines_next;
      c2      <= c2_next;
    end
  end

endmodule
